/* hw/rtl/tip_pkg.sv */
// Package for the tagged interval profiler: request and status codes,
// the request record passed from front to back, and table constants.
`timescale 1ns / 1ps
`default_nettype none
package tip_pkg;

  localparam int unsigned SlotCountDefault = 32;
  localparam int unsigned QueueDepth       = 2;
  localparam logic [63:0] MinReset         = 64'h0000_0000_FFFF_FFFF;
  localparam logic [31:0] CallsMax         = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ReqBegin = 2'd0,
    ReqEnd   = 2'd1,
    ReqClear = 2'd2,
    ReqNone  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    StStarted   = 3'd0,
    StRestarted = 3'd1,
    StStopped   = 3'd2,
    StNotFound  = 3'd3,
    StFull      = 3'd4,
    StCleared   = 3'd5,
    StNoBegin   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    BkIdle  = 2'd0,
    BkRead  = 2'd1,
    BkCalc  = 2'd2,
    BkOut   = 2'd3
  } bk_state_e;

  // Classified request handed to the back end; slot is a full 8-bit index.
  typedef struct packed {
    req_e        req;
    logic        hit;
    logic [7:0]  slot;
    logic [63:0] ts;
  } cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/tip_front.sv */
// Front end: accepts requests, matches tags against the slot table and
// allocates slots. Pushes classified commands into the queue. Uses tip_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tip_front #(
  parameter int unsigned SlotCount = tip_pkg::SlotCountDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [31:0]       tag_key_i,
  input  wire logic [63:0]       timestamp_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_stall_i,
  output tip_pkg::cmd_t          cmd_o,
  input  wire logic              busy_i
);
  localparam int unsigned IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  logic [SlotCount-1:0] used_q;
  logic [31:0]          tag_q [SlotCount];
  logic                 pend_q;
  tip_pkg::cmd_t        cmd_q;

  logic [SlotCount-1:0] match;
  logic                 hit, any_free;
  logic [IdxW-1:0]      hit_idx, free_idx;
  logic                 acc;

  // Parallel tag match and lowest-free search (independent elements).
  always_comb begin
    hit = 1'b0; hit_idx = '0; any_free = 1'b0; free_idx = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      match[i] = used_q[i] && (tag_q[i] == tag_key_i);
      if (match[i]) begin hit = 1'b1; hit_idx = IdxW'(i); end
      if (!used_q[i]) begin any_free = 1'b1; free_idx = IdxW'(i); end
    end
  end

  // One request in flight; table state is owned here between requests.
  assign stall_o     = pend_q || busy_i;
  assign acc         = valid_i && !stall_o;
  assign cmd_valid_o = pend_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      pend_q <= 1'b0;
    end else begin
      if (pend_q && !cmd_stall_i) pend_q <= 1'b0;
      if (acc) begin
        case (tip_pkg::req_e'(req_type_i))
          tip_pkg::ReqBegin: begin
            pend_q <= 1'b1;
            if (!hit && any_free) used_q[free_idx] <= 1'b1;
          end
          tip_pkg::ReqEnd:   pend_q <= 1'b1;
          tip_pkg::ReqClear: begin
            pend_q <= 1'b1;
            used_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Tag store and command payload.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q.ts  <= timestamp_i;
      if (tip_pkg::req_e'(req_type_i) == tip_pkg::ReqBegin && !hit && any_free) begin
        tag_q[free_idx] <= tag_key_i;
        cmd_q.hit  <= 1'b0;
        cmd_q.slot <= 8'(free_idx);
      end else begin
        cmd_q.hit  <= hit;
        cmd_q.slot <= 8'(hit_idx);
      end
      // A fresh allocation is flagged through hit=0; a begin on a full table
      // is passed on as a no-op command, which the back end reports as full.
      if (tip_pkg::req_e'(req_type_i) == tip_pkg::ReqBegin && !hit && !any_free)
        cmd_q.req <= tip_pkg::ReqNone;
      else
        cmd_q.req <= tip_pkg::req_e'(req_type_i);
    end
  end

  as_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !acc) else $error("accept while command pending");
  as_clear_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req_type_i == tip_pkg::ReqClear) |=> used_q == '0)
    else $error("clear left slots used");
  as_alloc_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req_type_i == tip_pkg::ReqBegin) |=> used_q[cmd_q.slot[IdxW-1:0]])
    else $error("begin slot not used");
endmodule
`default_nettype wire

/* hw/rtl/tip_back.sv */
// Back end: read-modify-write of the slot statistics memory and the result
// register. Uses tip_pkg. Stats live in one memory with a clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module tip_back #(
  parameter int unsigned SlotCount = tip_pkg::SlotCountDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_stall_o,
  input  wire tip_pkg::cmd_t cmd_i,
  output logic               busy_o,
  output logic               valid_o,
  input  wire logic          stall_i,
  output logic [2:0]         status_o,
  output logic [4:0]         slot_index_o,
  output logic [63:0]        duration_o,
  output logic [63:0]        total_time_o,
  output logic [63:0]        min_time_o,
  output logic [63:0]        max_time_o,
  output logic [31:0]        call_count_o,
  output logic               error_flag_o
);
  localparam int unsigned IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  typedef struct packed {
    logic        run;
    logic        err;
    logic [63:0] start;
    logic [63:0] total;
    logic [63:0] mn;
    logic [63:0] mx;
    logic [31:0] calls;
  } ent_t;

  ent_t mem_q [SlotCount];
  ent_t rd_q, wr_d;
  logic wr_en;

  tip_pkg::bk_state_e state_q, state_d;
  tip_pkg::cmd_t      c_q;
  logic               clr_q;
  logic [IdxW-1:0]    clr_idx_q;
  logic [63:0]        span;
  logic               out_v_q;
  ent_t               rpt;
  logic [2:0]         st;
  logic [63:0]        dur;
  logic               rpt_zero;
  logic               free_out;

  localparam ent_t EntReset = '{run: 1'b0, err: 1'b0, start: '0, total: '0,
                                mn: tip_pkg::MinReset, mx: '0, calls: '0};

  assign free_out    = !out_v_q || !stall_i;
  assign cmd_stall_o = (state_q != tip_pkg::BkIdle) || clr_q;
  assign busy_o      = clr_q;
  assign valid_o     = out_v_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tip_pkg::BkIdle: if (cmd_valid_i && !cmd_stall_o) state_d = tip_pkg::BkRead;
      tip_pkg::BkRead: state_d = tip_pkg::BkCalc;
      tip_pkg::BkCalc: state_d = tip_pkg::BkOut;
      tip_pkg::BkOut:  if (free_out) state_d = tip_pkg::BkIdle;
      default:         state_d = tip_pkg::BkIdle;
    endcase
  end

  // Update of the entry and result fields from the read data.
  always_comb begin
    wr_d = rd_q; st = tip_pkg::StStarted; dur = '0; rpt_zero = 1'b0; wr_en = 1'b0;
    case (c_q.req)
      tip_pkg::ReqBegin: begin
        wr_en = 1'b1;
        if (!c_q.hit) wr_d = EntReset;
        if (c_q.hit && rd_q.run) begin wr_d.err = 1'b1; st = tip_pkg::StRestarted; end
        wr_d.start = c_q.ts; wr_d.run = 1'b1;
      end
      tip_pkg::ReqEnd: begin
        if (!c_q.hit) begin st = tip_pkg::StNotFound; rpt_zero = 1'b1; end
        else if (!rd_q.run) st = tip_pkg::StNoBegin;
        else begin
          wr_en = 1'b1; st = tip_pkg::StStopped; dur = span;
          wr_d.total = rd_q.total + span;
          if (span < rd_q.mn) wr_d.mn = span;
          if (span > rd_q.mx) wr_d.mx = span;
          if (rd_q.calls != tip_pkg::CallsMax) wr_d.calls = rd_q.calls + 32'd1;
          wr_d.run = 1'b0; wr_d.start = '0;
        end
      end
      tip_pkg::ReqClear: begin st = tip_pkg::StCleared; rpt_zero = 1'b1; end
      default: begin st = tip_pkg::StFull; rpt_zero = 1'b1; end
    endcase
    rpt = wr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tip_pkg::BkIdle;
      out_v_q <= 1'b0;
      clr_q <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_v_q && !stall_i) out_v_q <= 1'b0;
      if (state_q == tip_pkg::BkCalc && free_out) out_v_q <= 1'b1;
      if (state_q == tip_pkg::BkCalc && c_q.req == tip_pkg::ReqClear) begin
        clr_q <= 1'b1; clr_idx_q <= '0;
      end else if (clr_q) begin
        if (32'(clr_idx_q) == SlotCount - 1) clr_q <= 1'b0;
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  // Memory port, command latch, duration and result registers.
  always_ff @(posedge clk_i) begin
    if (state_q == tip_pkg::BkIdle && cmd_valid_i && !cmd_stall_o) c_q <= cmd_i;
    if (clr_q) mem_q[clr_idx_q] <= EntReset;
    else if (state_q == tip_pkg::BkCalc && wr_en) mem_q[c_q.slot[IdxW-1:0]] <= wr_d;
    if (state_q == tip_pkg::BkRead) begin
      rd_q <= mem_q[c_q.slot[IdxW-1:0]];
    end
    if (state_q == tip_pkg::BkCalc && free_out) begin
      status_o     <= st;
      slot_index_o <= rpt_zero ? 5'd0 : c_q.slot[4:0];
      duration_o   <= dur;
      total_time_o <= rpt_zero ? 64'd0 : rpt.total;
      min_time_o   <= rpt_zero ? 64'd0 : rpt.mn;
      max_time_o   <= rpt_zero ? 64'd0 : rpt.mx;
      call_count_o <= rpt_zero ? 32'd0 : rpt.calls;
      error_flag_o <= rpt_zero ? 1'b0 : rpt.err;
    end
  end

  // Duration is taken from the entry read in the previous cycle.
  always_comb span = c_q.ts - rd_q.start;

  as_no_cmd_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> cmd_stall_o) else $error("command taken during clearing pass");
  as_calc_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tip_pkg::BkRead |=> state_q == tip_pkg::BkCalc) else $error("read skipped");
  as_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && stall_i) |=> out_v_q && $stable(status_o)) else $error("result dropped");
endmodule
`default_nettype wire

/* hw/rtl/tip_queue.sv */
// Two-entry command queue between front and back ends. Uses tip_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tip_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire tip_pkg::cmd_t in_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tip_pkg::cmd_t      out_o
);
  tip_pkg::cmd_t q_q [tip_pkg::QueueDepth];
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o  = cnt_q == 2'(tip_pkg::QueueDepth);
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o       = q_q[0];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_q + 2'(push) - 2'(pop);
  end

  // Shift register queue: head at entry 0; a push lands behind the last
  // entry that remains after a pop.
  always_ff @(posedge clk_i) begin
    if (pop) q_q[0] <= q_q[1];
    if (push) q_q[cnt_q[0] ^ pop] <= in_i;
  end
endmodule
`default_nettype wire

/* hw/rtl/tagged_interval_profiler_unit.sv */
// Top level of the tagged interval profiler.
// Front end (tag match and allocation), command queue, back end (statistics).
// Channels: request in (valid_i/stall_o, req_type_i, tag_key_i,
//   timestamp_i), result out (valid_o/stall_i and the result fields).
// A request is taken when valid is high and stall low. Each begin, end or
// clear gives exactly one result; request type three is dropped silently
// and the next request may follow in the next cycle.
// valid_o rises after the front command register, the queue, the back-end
// command latch, the memory read and the update. One request is in flight,
// so the next request is accepted only once the result has been taken;
// a result that waits under stall_i holds it off further.
// A clear adds the sweep of the statistics memory.
// At reset, and after every clear, the back end sweeps the statistics
// memory one slot a cycle and holds stall_o high.
// A stalled result holds its fields; further requests wait meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module tagged_interval_profiler_unit #(
  parameter int unsigned SlotCount = tip_pkg::SlotCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] tag_key_i,
  input  wire logic [63:0] timestamp_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [2:0]       status_o,
  output logic [4:0]       slot_index_o,
  output logic [63:0]      duration_o,
  output logic [63:0]      total_time_o,
  output logic [63:0]      min_time_o,
  output logic [63:0]      max_time_o,
  output logic [31:0]      call_count_o,
  output logic             error_flag_o
);
  tip_pkg::cmd_t f_cmd, b_cmd;
  logic f_v, f_s, b_v, b_s, busy, inflight_q, fin;
  logic stall_f;

  // One request in flight from accept to result hand-off.
  assign stall_o = stall_f || inflight_q;
  assign fin     = valid_o && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inflight_q <= 1'b0;
    else if (valid_i && !stall_o && req_type_i != 2'(tip_pkg::ReqNone)) inflight_q <= 1'b1;
    else if (fin) inflight_q <= 1'b0;
  end

  tip_front #(.SlotCount(SlotCount)) u_front (
    .clk_i, .rst_ni, .valid_i(valid_i && !inflight_q), .stall_o(stall_f),
    .req_type_i, .tag_key_i, .timestamp_i,
    .cmd_valid_o(f_v), .cmd_stall_i(f_s), .cmd_o(f_cmd), .busy_i(busy)
  );

  tip_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_v), .in_stall_o(f_s), .in_i(f_cmd),
    .out_valid_o(b_v), .out_stall_i(b_s), .out_o(b_cmd)
  );

  tip_back #(.SlotCount(SlotCount)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_v), .cmd_stall_o(b_s), .cmd_i(b_cmd),
    .busy_o(busy), .valid_o, .stall_i, .status_o, .slot_index_o, .duration_o,
    .total_time_o, .min_time_o, .max_time_o, .call_count_o, .error_flag_o
  );
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for tagged_interval_profiler_unit: a queued request driver, a result
// monitor and a slot-table predictor built from tip_pkg types and constants.
`timescale 1ns / 1ps
module testbench;
  import tip_pkg::*;

  localparam int unsigned Slots = SlotCountDefault;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] tag;
    logic [63:0] ts;
    bit          hold;  // wait for all results before sending
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [63:0] dur;
    logic [63:0] total;
    logic [63:0] tmin;
    logic [63:0] tmax;
    logic [31:0] calls;
    logic        err;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [1:0] req_type_i = '0;
  logic [31:0] tag_key_i = '0;
  logic [63:0] timestamp_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [2:0] status_o;
  logic [4:0] slot_index_o;
  logic [63:0] duration_o, total_time_o, min_time_o, max_time_o;
  logic [31:0] call_count_o;
  logic error_flag_o;

  tagged_interval_profiler_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the slot table
  bit          tbl_used[Slots];
  logic [31:0] tbl_tag[Slots];
  bit          tbl_run[Slots];
  logic [63:0] tbl_start[Slots];
  bit          tbl_err[Slots];
  logic [63:0] tbl_total[Slots];
  logic [63:0] tbl_min[Slots];
  logic [63:0] tbl_max[Slots];
  logic [31:0] tbl_calls[Slots];

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  function automatic void clear_table();
    for (int i = 0; i < Slots; i++) begin
      tbl_used[i] = 0; tbl_tag[i] = '0; tbl_run[i] = 0; tbl_start[i] = '0;
      tbl_err[i] = 0; tbl_total[i] = '0; tbl_min[i] = MinReset;
      tbl_max[i] = '0; tbl_calls[i] = '0;
    end
  endfunction

  function automatic result_t slot_result(status_e st, int s, logic [63:0] d);
    result_t r;
    r = '{st, '0, '0, '0, '0, '0, '0, 1'b0};
    if (s >= 0) begin
      r.slot = s[4:0]; r.dur = d; r.total = tbl_total[s]; r.tmin = tbl_min[s];
      r.tmax = tbl_max[s]; r.calls = tbl_calls[s]; r.err = tbl_err[s];
    end
    return r;
  endfunction

  // apply one request to the table and queue its result
  function automatic void profile_request(request_t rq);
    int s;
    logic [63:0] d;
    status_e st;
    s = -1;
    for (int i = Slots - 1; i >= 0; i--)
      if (tbl_used[i] && tbl_tag[i] == rq.tag) s = i;
    case (rq.req)
      ReqBegin: begin
        st = StStarted;
        if (s >= 0) begin
          if (tbl_run[s]) begin
            tbl_err[s] = 1; st = StRestarted;
          end
        end else begin
          for (int i = Slots - 1; i >= 0; i--)
            if (!tbl_used[i]) s = i;
          if (s >= 0) begin
            tbl_used[s] = 1; tbl_tag[s] = rq.tag;
          end
        end
        if (s < 0) expected_results.push_back(slot_result(StFull, -1, '0));
        else begin
          tbl_start[s] = rq.ts; tbl_run[s] = 1;
          expected_results.push_back(slot_result(st, s, '0));
        end
      end
      ReqEnd: begin
        if (s < 0) expected_results.push_back(slot_result(StNotFound, -1, '0));
        else if (!tbl_run[s]) expected_results.push_back(slot_result(StNoBegin, s, '0));
        else begin
          d = rq.ts - tbl_start[s];
          tbl_total[s] += d;
          if (d < tbl_min[s]) tbl_min[s] = d;
          if (d > tbl_max[s]) tbl_max[s] = d;
          if (tbl_calls[s] != CallsMax) tbl_calls[s]++;
          tbl_run[s] = 0; tbl_start[s] = '0;
          expected_results.push_back(slot_result(StStopped, s, d));
        end
      end
      ReqClear: begin
        clear_table();
        expected_results.push_back(slot_result(StCleared, -1, '0));
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void add_req(logic [1:0] rq, logic [31:0] tag, logic [63:0] ts,
                                  bit hold = 0);
    request_t r;
    r.req = rq; r.tag = tag; r.ts = ts; r.hold = hold;
    pending_reqs.push_back(r);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) profile_request('{req_type_i, tag_key_i, timestamp_i, 0});
      if (!valid_i || !stall_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct &&
            !(pending_reqs[0].hold && (expected_results.size() != 0 || valid_i))) begin
          valid_i <= 1'b1;
          req_type_i <= pending_reqs[0].req;
          tag_key_i <= pending_reqs[0].tag;
          timestamp_i <= pending_reqs[0].ts;
          void'(pending_reqs.pop_front());
        end else begin
          valid_i <= 1'b0;
        end
      end
      stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t e;
    cycles <= cycles + 1;
    if (rst_ni && valid_o && !stall_i) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, status %0d", status_o);
      end else begin
        e = expected_results.pop_front();
        if (status_o !== e.status || slot_index_o !== e.slot || duration_o !== e.dur ||
            total_time_o !== e.total || min_time_o !== e.tmin ||
            max_time_o !== e.tmax || call_count_o !== e.calls ||
            error_flag_o !== e.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st%0d sl%0d d%h t%h mn%h mx%h c%h e%b / got st%0d sl%0d d%h t%h mn%h mx%h c%h e%b",
                     e.status, e.slot, e.dur, e.total, e.tmin, e.tmax, e.calls, e.err,
                     status_o, slot_index_o, duration_o, total_time_o, min_time_o,
                     max_time_o, call_count_o, error_flag_o);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] tags[8];
    logic [63:0] tnow;
    int k;
    clear_table();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every request type, each corner case
    add_req(ReqEnd, 32'h0, 64'h0);                         // end, tag unknown
    add_req(ReqBegin, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
    add_req(ReqEnd, 32'hFFFF_FFFF, 64'h5);                 // wraps in time
    add_req(ReqEnd, 32'hFFFF_FFFF, 64'h9);                 // end on stopped slot
    add_req(ReqBegin, 32'h0, 64'h0);
    add_req(ReqBegin, 32'h0, 64'h10);                      // begin while running
    add_req(ReqEnd, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);       // huge duration
    add_req(ReqNone, 32'h1234, 64'h1);                     // ignored type
    add_req(ReqBegin, 32'hFFFF_FFFF, 64'h100);
    add_req(ReqEnd, 32'hFFFF_FFFF, 64'h100);               // zero duration
    for (int i = 0; i < Slots; i++) add_req(ReqBegin, 32'h100 + 32'(i), 64'(i));
    add_req(ReqBegin, 32'hDEAD_BEEF, 64'h7);               // table full
    add_req(ReqClear, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(ReqEnd, 32'h100, 64'h1);                       // after clear, unknown
    drain();

    // random: four phases of idle and stall rates, mostly begin/end requests on eight tags
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 65 : 12) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 65 : 12) : 0;
      for (int i = 0; i < 8; i++) tags[i] = ($urandom_range(3) == 0) ? $urandom() : 32'(i);
      tnow = rand64();
      for (int n = 0; n < 150; n++) begin
        k = $urandom_range(99);
        tnow += ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(5000));
        if (k < 45) add_req(ReqBegin, tags[$urandom_range(7)], tnow);
        else if (k < 88) add_req(ReqEnd, tags[$urandom_range(7)], tnow);
        else if (k < 94) add_req(ReqEnd, $urandom(), rand64());
        else if (k < 96) add_req(ReqClear, $urandom(), rand64());
        else if (k < 98) add_req(ReqNone, $urandom(), rand64());
        else add_req(ReqBegin, $urandom(), rand64());
        if (n == 75) pending_reqs[$].hold = 1;           // pause until drained
      end
      drain();
    end
    repeat (40) @(posedge clk_i);
    $display("Covered begin, end, clear and ignored requests over %0d results,", results_seen);
    $display("with table-full, restart, unmatched-end and wraparound cases.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
